>>> src/ppr_pkg.sv
// ----------------------------------------------------------------------------
// ppr_pkg
// Shared types and constants of the piecewise projective remap.
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam int unsigned CoeffBits = 40;
  localparam int unsigned Slots     = 9;
  localparam int unsigned OutBits   = 28;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned QuotBits  = 29;
  localparam int unsigned OvfShift  = 20;
  localparam int unsigned PreStages = 5;

  localparam logic OpLoad = 1'b0;
  localparam logic OpMap  = 1'b1;

  typedef struct packed {
    logic neg;
    logic ovf;
  } lane_flags_t;

endpackage

>>> src/piecewise_projective_remap.sv
// ----------------------------------------------------------------------------
// piecewise_projective_remap
// Maps destination pixels through per-triangle inverse homographies.
// ----------------------------------------------------------------------------
// A request with tuser 0 writes one coefficient of a triangle's matrix; one
// with tuser 1 maps a pixel and yields one result. The block takes one request
// every cycle unless the result side stalls. It has 35 register stages: five
// stages of table read, multiply, row sum, magnitude and range check, the
// 29-stage quotient pipeline and the output register. The first stage is
// loaded by the edge that accepts the request. A stall on the result side
// holds the whole pipeline and the input. A load is visible to a map request
// in the very next cycle.
module piecewise_projective_remap
  import ppr_pkg::*;
#(
  parameter int unsigned MAX_TRIANGLES = 256,
  parameter int unsigned COORD_BITS    = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // label[8:0], coeff_slot[12:9], coeff_value[52:13], pixel_x[64:53],
  // pixel_y[76:65], zero pad [79:77]
  input  logic [79:0] s_axis_tdata_i,
  // opcode[0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // source_x[27:0], source_y[55:28]
  output logic [55:0] m_axis_tdata_o
);

  localparam int unsigned AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned PW = CoeffBits + CW + 1;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned ND = PreStages + QuotBits;

  typedef struct packed {
    logic          ident;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
  } side_t;

  logic                 adv;
  logic [8:0]           in_label;
  logic [3:0]           in_slot;
  logic [CoeffBits-1:0] in_coeff;
  logic [15:0]          in_x16;
  logic [15:0]          in_y16;
  logic                 label_ok;
  logic [AW-1:0]        tri_addr;
  logic                 in_map;

  assign adv      = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign in_label = s_axis_tdata_i[8:0];
  assign in_slot  = s_axis_tdata_i[12:9];
  assign in_coeff = s_axis_tdata_i[52:13];
  assign in_x16   = 16'(s_axis_tdata_i[64:53]);
  assign in_y16   = 16'(s_axis_tdata_i[76:65]);
  assign label_ok = (in_label != 9'd0) && (32'(in_label) <= MAX_TRIANGLES);
  assign tri_addr = AW'(in_label - 9'd1);
  assign in_map   = s_axis_tvalid_i && (s_axis_tuser_i == OpMap);

  logic [CoeffBits-1:0] h [Slots];

  for (genvar s = 0; s < Slots; s++) begin : g_ram
    ppr_ram #(
      .WIDTH(CoeffBits),
      .DEPTH(MAX_TRIANGLES)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (adv && s_axis_tvalid_i && (s_axis_tuser_i == OpLoad) && label_ok &&
               (in_slot == 4'(s))),
      .waddr_i(tri_addr),
      .wdata_i(in_coeff),
      .re_i   (adv),
      .raddr_i(tri_addr),
      .rdata_o(h[s])
    );
  end

  side_t side_q [ND];
  side_t side_d;
  logic  v1_q, v2_q, v3_q, v4_q, v5_q;

  always_comb begin
    side_d.ident = !label_ok;
    side_d.x     = in_x16[CW-1:0];
    side_d.y     = in_y16[CW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_map;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      for (int i = 1; i < ND; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  logic signed [PW-1:0]        prod_q [6];
  logic signed [CoeffBits-1:0] cst_q  [3];
  logic signed [CW:0]          xs;
  logic signed [CW:0]          ys;

  assign xs = $signed({1'b0, side_q[0].x});
  assign ys = $signed({1'b0, side_q[0].y});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        prod_q[2*r]   <= PW'($signed(h[3*r])) * PW'(xs);
        prod_q[2*r+1] <= PW'($signed(h[3*r+1])) * PW'(ys);
        cst_q[r]      <= $signed(h[3*r+2]);
      end
    end
  end

  logic signed [SW-1:0] sum_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        sum_q[r] <= SW'(prod_q[2*r]) + SW'(prod_q[2*r+1]) + SW'(cst_q[r]);
      end
    end
  end

  logic [SW-1:0] ax_q, ay_q, bz_q;
  logic          nx_q, ny_q, nz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q <= sum_q[0][SW-1] ? SW'(-sum_q[0]) : SW'(sum_q[0]);
      ay_q <= sum_q[1][SW-1] ? SW'(-sum_q[1]) : SW'(sum_q[1]);
      bz_q <= (sum_q[2] == '0) ? SW'(1) :
              (sum_q[2][SW-1] ? SW'(-sum_q[2]) : SW'(sum_q[2]));
      nx_q <= sum_q[0][SW-1];
      ny_q <= sum_q[1][SW-1];
      nz_q <= sum_q[2][SW-1];
    end
  end

  logic [SW-1:0] ax5_q, ay5_q, bz5_q;
  lane_flags_t   fx5_q, fy5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax5_q     <= ax_q;
      ay5_q     <= ay_q;
      bz5_q     <= bz_q;
      fx5_q.neg <= nx_q ^ nz_q;
      fy5_q.neg <= ny_q ^ nz_q;
      fx5_q.ovf <= (SW+OvfShift)'(ax_q) >= ((SW+OvfShift)'(bz_q) << OvfShift);
      fy5_q.ovf <= (SW+OvfShift)'(ay_q) >= ((SW+OvfShift)'(bz_q) << OvfShift);
    end
  end

  logic                dvx, dvy;
  logic [QuotBits-1:0] qx, qy;
  lane_flags_t         fx, fy;

  ppr_div #(.NW(SW)) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(v5_q),
    .num_i  (ax5_q),
    .den_i  (bz5_q),
    .flags_i(fx5_q),
    .valid_o(dvx),
    .quot_o (qx),
    .flags_o(fx)
  );

  ppr_div #(.NW(SW)) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(v5_q),
    .num_i  (ay5_q),
    .den_i  (bz5_q),
    .flags_i(fy5_q),
    .valid_o(dvy),
    .quot_o (qy),
    .flags_o(fy)
  );

  function automatic logic [OutBits-1:0] finish(input logic [QuotBits-1:0] q,
                                                input lane_flags_t f);
    logic [QuotBits:0] r;
    logic [QuotBits:0] lim;
    logic [QuotBits:0] mag;
    r   = ({1'b0, q} + (QuotBits+1)'(1)) >> 1;
    lim = f.neg ? (QuotBits+1)'(1) << (OutBits - 1)
                : ((QuotBits+1)'(1) << (OutBits - 1)) - (QuotBits+1)'(1);
    mag = (f.ovf || (r > lim)) ? lim : r;
    return f.neg ? OutBits'(-mag) : OutBits'(mag);
  endfunction

  logic               out_valid_q;
  logic [OutBits-1:0] sx_q, sy_q;
  side_t              last_side;

  assign last_side = side_q[ND-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dvx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_q <= last_side.ident ? OutBits'(last_side.x) << FracBits : finish(qx, fx);
      sy_q <= last_side.ident ? OutBits'(last_side.y) << FracBits : finish(qy, fy);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {sy_q, sx_q};

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dvx == dvy)
    else $error("divider lanes out of step");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v5_q) && $stable(dvx))
    else $error("pipeline moved during stall");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> bz5_q != '0)
    else $error("zero divisor reached divider");

endmodule

>>> src/ppr_ram.sv
// ----------------------------------------------------------------------------
// ppr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ppr_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ppr_div.sv
// ----------------------------------------------------------------------------
// ppr_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module ppr_div
  import ppr_pkg::*;
#(
  parameter int unsigned NW = 55
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [NW-1:0]       num_i,
  input  logic [NW-1:0]       den_i,
  input  lane_flags_t         flags_i,
  output logic                valid_o,
  output logic [QuotBits-1:0] quot_o,
  output lane_flags_t         flags_o
);

  localparam int unsigned DW = NW + QuotBits;

  logic                valid_q [QuotBits+1];
  logic [DW-1:0]       rem_q   [QuotBits+1];
  logic [NW-1:0]       den_q   [QuotBits+1];
  logic [QuotBits-1:0] quot_q  [QuotBits+1];
  lane_flags_t         flags_q [QuotBits+1];

  always_comb begin
    valid_q[0] = valid_i;
    rem_q[0]   = DW'(num_i) << 9;
    den_q[0]   = den_i;
    quot_q[0]  = '0;
    flags_q[0] = flags_i;
  end

  for (genvar k = 0; k < QuotBits; k++) begin : g_stage
    localparam int unsigned Sh = QuotBits - 1 - k;
    logic [DW-1:0]       dsh;
    logic                take;
    logic [DW-1:0]       rem_d;
    logic [QuotBits-1:0] quot_d;

    always_comb begin
      dsh    = DW'(den_q[k]) << Sh;
      take   = rem_q[k] >= dsh;
      rem_d  = take ? (rem_q[k] - dsh) : rem_q[k];
      quot_d = quot_q[k];
      quot_d[Sh] = take;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]   <= rem_d;
        den_q[k+1]   <= den_q[k];
        quot_q[k+1]  <= quot_d;
        flags_q[k+1] <= flags_q[k];
      end
    end
  end

  assign valid_o = valid_q[QuotBits];
  assign quot_o  = quot_q[QuotBits];
  assign flags_o = flags_q[QuotBits];

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[QuotBits] && !flags_q[QuotBits].ovf |->
      rem_q[QuotBits] < DW'(den_q[QuotBits]))
    else $error("divider remainder not below divisor");

endmodule
